// ===== rtl/core/asc_pkg.sv =====
// Shared constants, types and codes of the affine substitution cipher.
package asc_pkg;

  // Alphabet storage.
  localparam int MAX_SYMBOLS = 64;
  localparam int ADDR_W      = $clog2(MAX_SYMBOLS);
  localparam int N_W         = $clog2(MAX_SYMBOLS + 1);

  // Fixed field widths.
  localparam int SYM_W     = 8;
  localparam int CMD_W     = 2;
  localparam int IDX_W     = 6;
  localparam int KEY_W     = 8;
  localparam int SIZE_W    = 7;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;

  // Commands carried by an input item.
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENCRYPT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DECRYPT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MUL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SHIFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SIZE = 2'd2;

  // Register reset values.
  localparam logic [KEY_W-1:0]  KEY_MUL_RST    = 8'd1;
  localparam logic [KEY_W-1:0]  KEY_SHIFT_RST  = 8'd0;
  localparam logic [SIZE_W-1:0] ALPHA_SIZE_RST = 7'd26;

  // A residue modulo the alphabet size, and the size itself.
  typedef logic [ADDR_W-1:0] res_t;
  typedef logic [N_W-1:0]    size_t;

  // One request to the shared modular adder: x + y + cin, reduced once.
  typedef struct packed {
    res_t  x;
    size_t y;
    logic  cin;
  } asc_op_t;

endpackage

// ===== rtl/core/asc_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface asc_in_if
  import asc_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [IDX_W-1:0] entry_index;
  logic [SYM_W-1:0] symbol_in;

  modport source (output valid, output command, output entry_index, output symbol_in,
                  input ready);
  modport sink   (input valid, input command, input entry_index, input symbol_in,
                  output ready);
endinterface

interface asc_out_if
  import asc_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol_out;
  logic             found;
  logic             key_invalid;

  modport source (output valid, output symbol_out, output found, output key_invalid,
                  input ready);
  modport sink   (input valid, input symbol_out, input found, input key_invalid,
                  output ready);
endinterface

// ===== rtl/core/asc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module asc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/asc_modadd.sv =====
// Shared modular adder: (x + y + cin) mod n for a sum below 2n.
module asc_modadd
  import asc_pkg::*;
(
  input  asc_op_t op,
  input  size_t   modulus,
  output res_t    result
);

  logic [N_W:0] sum;
  logic [N_W:0] diff;

  // One add, one compare and one conditional subtract.
  always_comb begin
    sum  = (N_W+1)'(op.x) + (N_W+1)'(op.y) + (N_W+1)'(op.cin);
    diff = sum - (N_W+1)'(modulus);
    if (sum >= (N_W+1)'(modulus)) begin
      result = diff[ADDR_W-1:0];
    end else begin
      result = sum[ADDR_W-1:0];
    end
  end

endmodule

// ===== rtl/core/affine_substitution_cipher.sv =====
// Flow: a load item ends when it is accepted; encrypt or decrypt goes to S_OUT at size 0, else
// through S_REDA, S_REDB, S_SEARCH, S_TGT (decrypt hit), S_SCAN, S_ENC (encrypt), S_READ, S_OUT.
// Throughput: one item at a time; in_ch.ready is low until the result enters the output register.
// The time per item is set by the one-entry-per-cycle alphabet search over the RAM read port and by
// the key scan, which steps the shared modular adder once per residue.
// Reset (synchronous, rst_n low): keys return to 1 and 0, size to 26; the alphabet is not cleared.
module affine_substitution_cipher
  import asc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  asc_in_if.sink               in_ch,
  asc_out_if.source            out_ch
);

  localparam int CNT_W = $clog2(KEY_W);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_REDA   = 9'b000000010,
    S_REDB   = 9'b000000100,
    S_SEARCH = 9'b000001000,
    S_TGT    = 9'b000010000,
    S_SCAN   = 9'b000100000,
    S_ENC    = 9'b001000000,
    S_READ   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  // Configuration registers.
  logic [KEY_W-1:0]  key_mul_r;
  logic [KEY_W-1:0]  key_shift_r;
  logic [SIZE_W-1:0] alpha_size_r;

  // Sequencer state.
  state_t            state_r, state_nxt;
  logic              is_dec_r, is_dec_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  size_t             n_r, n_nxt;
  logic [KEY_W-1:0]  a_r, a_nxt;
  logic [KEY_W-1:0]  sh_r, sh_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  res_t              ap_r, ap_nxt;
  res_t              bp_r, bp_nxt;
  size_t             i_r, i_nxt;
  logic              chk_v_r, chk_v_nxt;
  res_t              chk_idx_r, chk_idx_nxt;
  logic              found_r, found_nxt;
  res_t              pos_r, pos_nxt;
  res_t              t_r, t_nxt;
  res_t              k_r, k_nxt;
  res_t              q_r, q_nxt;
  logic              seen1_r, seen1_nxt;
  res_t              kres_r, kres_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]  out_sym_r, out_sym_nxt;
  logic              out_found_r, out_found_nxt;
  logic              out_inv_r, out_inv_nxt;

  // Datapath signals.
  logic              in_fire;
  logic              is_cipher;
  size_t             n_eff;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [SYM_W-1:0]  ram_rdata;
  asc_op_t           op;
  res_t              mod_out;
  logic              search_hit;
  logic              search_done;
  logic              key_ok;
  logic              out_load;

  // Alphabet storage.
  asc_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_SYMBOLS)
  ) u_alpha_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.symbol_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The one modular adder, shared by the reduction, target, scan and encrypt steps of the sequencer.
  asc_modadd u_modadd (
    .op      (op),
    .modulus (n_r),
    .result  (mod_out)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mul_r    <= KEY_MUL_RST;
      key_shift_r  <= KEY_SHIFT_RST;
      alpha_size_r <= ALPHA_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_MUL:    key_mul_r    <= cfg_wdata;
        REG_KEY_SHIFT:  key_shift_r  <= cfg_wdata;
        REG_ALPHA_SIZE: alpha_size_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake and alphabet loads.
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_cipher   = (in_ch.command == CMD_ENCRYPT) || (in_ch.command == CMD_DECRYPT);
  assign ram_we      = in_fire && (in_ch.command == CMD_LOAD) &&
                       (int'(in_ch.entry_index) < MAX_SYMBOLS);
  assign ram_waddr   = ADDR_W'(in_ch.entry_index);
  assign n_eff       = (int'(alpha_size_r) > MAX_SYMBOLS) ? N_W'(MAX_SYMBOLS)
                                                          : N_W'(alpha_size_r);

  // Key validity: gcd(a, 0) = a; for n = 1 always valid; otherwise a has an inverse.
  always_comb begin
    if (n_r == '0) begin
      key_ok = (a_r == KEY_W'(1));
    end else begin
      key_ok = (n_r == N_W'(1)) || seen1_r;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    is_dec_nxt    = is_dec_r;
    sym_nxt       = sym_r;
    n_nxt         = n_r;
    a_nxt         = a_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    ap_nxt        = ap_r;
    bp_nxt        = bp_r;
    i_nxt         = i_r;
    chk_v_nxt     = chk_v_r;
    chk_idx_nxt   = chk_idx_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    t_nxt         = t_r;
    k_nxt         = k_r;
    q_nxt         = q_r;
    seen1_nxt     = seen1_r;
    kres_nxt      = kres_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_sym_nxt   = out_sym_r;
    out_found_nxt = out_found_r;
    out_inv_nxt   = out_inv_r;
    op.x          = '0;
    op.y          = '0;
    op.cin        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = i_r[ADDR_W-1:0];
    search_hit    = 1'b0;
    search_done   = 1'b0;
    out_load      = 1'b0;

    case (state_r)
      // Take an item; loads finish here.
      S_IDLE: begin
        if (in_fire && is_cipher) begin
          is_dec_nxt = (in_ch.command == CMD_DECRYPT);
          sym_nxt    = in_ch.symbol_in;
          n_nxt      = n_eff;
          a_nxt      = key_mul_r;
          sh_nxt     = key_mul_r;
          cnt_nxt    = '0;
          ap_nxt     = '0;
          found_nxt  = 1'b0;
          state_nxt  = (n_eff == '0) ? S_OUT : S_REDA;
        end
      end

      // Reduce a modulo n, one key bit per cycle, most significant first.
      S_REDA: begin
        op.x    = ap_r;
        op.y    = N_W'(ap_r);
        op.cin  = sh_r[KEY_W-1];
        ap_nxt  = mod_out;
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(KEY_W - 1)) begin
          sh_nxt    = key_shift_r;
          bp_nxt    = '0;
          state_nxt = S_REDB;
        end
      end

      // Reduce b modulo n the same way.
      S_REDB: begin
        op.x    = bp_r;
        op.y    = N_W'(bp_r);
        op.cin  = sh_r[KEY_W-1];
        bp_nxt  = mod_out;
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(KEY_W - 1)) begin
          i_nxt     = '0;
          chk_v_nxt = 1'b0;
          state_nxt = S_SEARCH;
        end
      end

      // Read one entry per cycle and compare the entry from the previous read.
      S_SEARCH: begin
        ram_re      = 1'b1;
        ram_raddr   = i_r[ADDR_W-1:0];
        i_nxt       = i_r + N_W'(1);
        chk_v_nxt   = 1'b1;
        chk_idx_nxt = i_r[ADDR_W-1:0];
        if (chk_v_r) begin
          if (ram_rdata == sym_r) begin
            search_hit  = 1'b1;
            search_done = 1'b1;
          end else if (N_W'(chk_idx_r) == n_r - N_W'(1)) begin
            search_done = 1'b1;
          end
        end
        if (search_hit) begin
          found_nxt = 1'b1;
          pos_nxt   = chk_idx_r;
        end
        if (search_done) begin
          chk_v_nxt = 1'b0;
          k_nxt     = '0;
          q_nxt     = '0;
          seen1_nxt = 1'b0;
          state_nxt = (is_dec_r && search_hit) ? S_TGT : S_SCAN;
        end
      end

      // Decrypt target: (pos - b) mod n.
      S_TGT: begin
        op.x      = pos_r;
        op.y      = n_r - N_W'(bp_r);
        t_nxt     = mod_out;
        state_nxt = S_SCAN;
      end

      // Walk q = a*k mod n over all k: spots the inverse and the wanted index.
      S_SCAN: begin
        op.x  = q_r;
        op.y  = N_W'(ap_r);
        q_nxt = mod_out;
        k_nxt = k_r + ADDR_W'(1);
        if (q_r == res_t'(1)) begin
          seen1_nxt = 1'b1;
        end
        if (is_dec_r && (q_r == t_r)) begin
          kres_nxt = k_r;
        end
        if (!is_dec_r && (k_r == pos_r)) begin
          kres_nxt = q_r;
        end
        if (N_W'(k_r) == n_r - N_W'(1)) begin
          state_nxt = is_dec_r ? S_READ : S_ENC;
        end
      end

      // Encrypt index: a*pos + b mod n.
      S_ENC: begin
        op.x      = kres_r;
        op.y      = N_W'(bp_r);
        kres_nxt  = mod_out;
        state_nxt = S_READ;
      end

      // Fetch the answering entry.
      S_READ: begin
        ram_re    = 1'b1;
        ram_raddr = kres_r;
        state_nxt = S_OUT;
      end

      // Hand the item to the output register once it is free.
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_sym_nxt   = (key_ok && found_r) ? ram_rdata : sym_r;
          out_found_nxt = found_r;
          out_inv_nxt   = !key_ok;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      chk_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      chk_v_r     <= chk_v_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    is_dec_r    <= is_dec_nxt;
    sym_r       <= sym_nxt;
    n_r         <= n_nxt;
    a_r         <= a_nxt;
    sh_r        <= sh_nxt;
    cnt_r       <= cnt_nxt;
    ap_r        <= ap_nxt;
    bp_r        <= bp_nxt;
    i_r         <= i_nxt;
    chk_idx_r   <= chk_idx_nxt;
    pos_r       <= pos_nxt;
    t_r         <= t_nxt;
    k_r         <= k_nxt;
    q_r         <= q_nxt;
    seen1_r     <= seen1_nxt;
    kres_r      <= kres_nxt;
    out_sym_r   <= out_sym_nxt;
    out_found_r <= out_found_nxt;
    out_inv_r   <= out_inv_nxt;
  end

  // Result channel.
  assign out_ch.valid       = out_valid_r;
  assign out_ch.symbol_out  = out_sym_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.key_invalid = out_inv_r;

  // A found position always lies inside the alphabet in use.
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (N_W'(pos_r) < n_r))
    else $error("found position outside the alphabet");

  // The scan residue stays reduced.
  a_scan_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (N_W'(q_r) < n_r))
    else $error("scan residue not reduced");

  // The answering entry read is inside the alphabet whenever it is used.
  a_answer_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_READ) && found_r && key_ok) |-> (N_W'(kres_r) < n_r))
    else $error("answer index outside the alphabet");

  // A symbol not in the alphabet leaves unchanged.
  a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !found_r) |-> (out_sym_nxt == sym_r))
    else $error("unfound symbol was altered");

endmodule

// ===== test/affine_cipher_checker.sv =====
// Checker for the affine substitution cipher: predicts every result item and compares it.
module affine_cipher_checker
  import asc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  asc_in_if                    in_mon,
  asc_out_if                   out_mon,
  output int                   fail_count,
  output int                   pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SYM_W-1:0] symbol_out;
    logic             found;
    logic             key_invalid;
  } cipher_result_t;

  // Shadow copy of the configuration registers and the alphabet.
  logic [KEY_W-1:0]  mul_key;
  logic [KEY_W-1:0]  shift_key;
  logic [SIZE_W-1:0] size_reg;
  logic [SYM_W-1:0]  alphabet_q [MAX_SYMBOLS];

  cipher_result_t cipher_results_q [$];

  function automatic int gcd_of(int x, int y);
    int t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // The modulus is at most 64, so a plain search finds the inverse.
  // With a modulus of one every residue is zero, and zero is returned.
  function automatic int inverse_mod(int x, int m);
    for (int v = 0; v < m; v++) begin
      if ((x * v) % m == 1 % m) return v;
    end
    return 0;
  endfunction

  // Works out the result item of one encrypt or decrypt item.
  function automatic cipher_result_t cipher_symbol(logic [CMD_W-1:0] cmd,
                                                    logic [SYM_W-1:0] sym);
    cipher_result_t r;
    int n, a, pos, shift, k;
    bit hit, key_ok;
    n = (int'(size_reg) > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(size_reg);
    a = int'(mul_key);
    hit = 1'b0;
    pos = 0;
    for (int i = 0; i < n; i++) begin
      if (!hit && alphabet_q[i] == sym) begin
        hit = 1'b1;
        pos = i;
      end
    end
    key_ok = (gcd_of(a, n) == 1);
    r.symbol_out  = sym;
    r.found       = hit;
    r.key_invalid = !key_ok;
    if (key_ok && hit && n != 0) begin
      shift = int'(shift_key) % n;
      if (cmd == CMD_ENCRYPT) begin
        k = ((a % n) * pos + shift) % n;
      end else begin
        k = (inverse_mod(a, n) * ((pos + n - shift) % n)) % n;
      end
      r.symbol_out = alphabet_q[k];
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    cipher_result_t want;
    if (!rst_n) begin
      mul_key    = KEY_MUL_RST;
      shift_key  = KEY_SHIFT_RST;
      size_reg   = ALPHA_SIZE_RST;
      fail_count = 0;
      cipher_results_q.delete();
    end else begin
      // Register writes; an unknown index changes nothing.
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_MUL:    mul_key = cfg_wdata[KEY_W-1:0];
          REG_KEY_SHIFT:  shift_key = cfg_wdata[KEY_W-1:0];
          REG_ALPHA_SIZE: size_reg = cfg_wdata[SIZE_W-1:0];
          default: ;
        endcase
      end

      // Compare an accepted result item with the oldest prediction.
      if (out_mon.valid && out_mon.ready) begin
        if (cipher_results_q.size() == 0) begin
          $error("result item with no request waiting: symbol_out %0d", out_mon.symbol_out);
          fail_count++;
        end else begin
          want = cipher_results_q.pop_front();
          if (out_mon.symbol_out !== want.symbol_out) begin
            $error("symbol_out mismatch: expected %0d, got %0d",
                   want.symbol_out, out_mon.symbol_out);
            fail_count++;
          end
          if (out_mon.found !== want.found) begin
            $error("found mismatch: expected %0d, got %0d", want.found, out_mon.found);
            fail_count++;
          end
          if (out_mon.key_invalid !== want.key_invalid) begin
            $error("key_invalid mismatch: expected %0d, got %0d",
                   want.key_invalid, out_mon.key_invalid);
            fail_count++;
          end
        end
      end

      // An accepted load updates the alphabet; encrypt and decrypt give one result.
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_LOAD) begin
          alphabet_q[in_mon.entry_index] = in_mon.symbol_in;
        end else if (in_mon.command == CMD_ENCRYPT || in_mon.command == CMD_DECRYPT) begin
          cipher_results_q.push_back(cipher_symbol(in_mon.command, in_mon.symbol_in));
        end
      end
    end
    pending_results = cipher_results_q.size();
  end

endmodule

// ===== test/tb_affine_substitution_cipher.sv =====
// Top of the affine substitution cipher testbench: stimulus, idling and the verdict.
module tb_affine_substitution_cipher
  import asc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0]     CMD_NONE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Covers the slowest item, at a full alphabet.
  localparam int DRAIN_CYCLES = 160;
  localparam int QUIET_LIMIT  = 2000;
  localparam int MAX_GAP      = 20;
  localparam int MAX_STALL    = 20;
  localparam int PHASE_ITEMS  = 500;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int fail_count;
  int pending_results;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int alphabet_len  = 26;

  // Bytes loaded so far, used to pick symbols that hit the alphabet.
  logic [SYM_W-1:0] loaded_bytes [MAX_SYMBOLS];

  asc_in_if  in_ch ();
  asc_out_if out_ch ();

  affine_substitution_cipher u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  affine_cipher_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, each run of low ready bounded by MAX_STALL.
  initial begin : result_sink
    int low_run;
    out_ch.ready = 1'b0;
    low_run = 0;
    forever begin
      @(negedge clk);
      if (low_run < MAX_STALL && $urandom_range(99) < recv_idle_pct) begin
        out_ch.ready <= 1'b0;
        low_run++;
      end else begin
        out_ch.ready <= 1'b1;
        low_run = 0;
      end
    end
  end

  // Ends the run when no item moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Offers one item after an optional random gap and returns once it is accepted.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic [SYM_W-1:0] sym);
    int gap;
    gap = 0;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do begin
        @(negedge clk);
        gap++;
      end while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.entry_index <= idx;
    in_ch.symbol_in   <= sym;
    if (cmd == CMD_LOAD) loaded_bytes[idx] = sym;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops sending, waits for every result, then waits out DRAIN_CYCLES.
  task automatic quiesce();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_ALPHA_SIZE) begin
      alphabet_len = (int'(value[SIZE_W-1:0]) > MAX_SYMBOLS) ? MAX_SYMBOLS
                                                              : int'(value[SIZE_W-1:0]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Picks a new key and size between segments, with the extremes often.
  task automatic new_settings();
    int r;
    logic [CFG_W-1:0] value;
    quiesce();
    r = $urandom_range(99);
    if (r < 10) value = 8'd0;
    else if (r < 20) value = 8'd255;
    else if (r < 30) value = 8'd1;
    else value = CFG_W'($urandom);
    write_reg(REG_KEY_MUL, value);

    r = $urandom_range(99);
    if (r < 15) value = 8'd0;
    else if (r < 30) value = 8'd255;
    else value = CFG_W'($urandom);
    write_reg(REG_KEY_SHIFT, value);

    // Mostly small alphabets keep the run short; a few full and oversized ones.
    r = $urandom_range(99);
    if (r < 6) value = 8'd0;
    else if (r < 12) value = 8'd64;
    else if (r < 18) value = CFG_W'($urandom_range(65, 255));
    else if (r < 28) value = 8'd26;
    else if (r < 34) value = 8'd1;
    else value = CFG_W'($urandom_range(2, 16));
    write_reg(REG_ALPHA_SIZE, value);

    if ($urandom_range(7) == 0) write_reg(REG_UNUSED, CFG_W'($urandom));
  endtask

  initial begin : stimulus
    int seg_len;
    int sent;
    int r;
    logic [CMD_W-1:0] cmd;
    logic [SYM_W-1:0] sym;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_LOAD;
    in_ch.entry_index = '0;
    in_ch.symbol_in   = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a four-entry alphabet with a repeated byte, keys still at reset.
    write_reg(REG_ALPHA_SIZE, 8'd4);
    send_item(CMD_LOAD, 6'd0, 8'h00);
    send_item(CMD_LOAD, 6'd1, 8'hFF);
    send_item(CMD_LOAD, 6'd2, 8'hA5);
    send_item(CMD_LOAD, 6'd3, 8'hFF);
    send_item(CMD_LOAD, 6'd63, 8'h5A);
    send_item(CMD_ENCRYPT, 6'd0, 8'h00);
    send_item(CMD_DECRYPT, 6'd0, 8'hFF);

    // Largest shift, valid multiplier; a byte stored past the size is not found.
    quiesce();
    write_reg(REG_KEY_MUL, 8'd3);
    write_reg(REG_KEY_SHIFT, 8'd255);
    send_item(CMD_ENCRYPT, 6'd0, 8'h00);
    send_item(CMD_ENCRYPT, 6'd63, 8'hFF);
    send_item(CMD_ENCRYPT, 6'd0, 8'hA5);
    send_item(CMD_ENCRYPT, 6'd0, 8'h5A);
    send_item(CMD_DECRYPT, 6'd0, 8'hFF);
    send_item(CMD_DECRYPT, 6'd0, 8'hA5);
    send_item(CMD_DECRYPT, 6'd0, 8'h00);
    send_item(CMD_NONE, 6'd63, 8'hFF);

    // Multiplier sharing a factor with the size: bytes pass unchanged.
    quiesce();
    write_reg(REG_KEY_MUL, 8'd2);
    send_item(CMD_ENCRYPT, 6'd0, 8'hA5);
    send_item(CMD_DECRYPT, 6'd0, 8'h11);

    // Empty alphabet, first with a unit multiplier and then with zero.
    quiesce();
    write_reg(REG_ALPHA_SIZE, 8'd0);
    write_reg(REG_KEY_MUL, 8'd1);
    send_item(CMD_ENCRYPT, 6'd0, 8'h00);
    quiesce();
    write_reg(REG_KEY_MUL, 8'd0);
    send_item(CMD_DECRYPT, 6'd0, 8'h00);

    // One-entry alphabet: a zero multiplier is still a valid key.
    quiesce();
    write_reg(REG_ALPHA_SIZE, 8'd1);
    send_item(CMD_ENCRYPT, 6'd0, 8'h00);
    send_item(CMD_DECRYPT, 6'd0, 8'hFF);

    // Fill the whole table so that any later size reads written entries only.
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      sym = (i > 0 && $urandom_range(7) == 0) ? loaded_bytes[$urandom_range(i - 1)]
                                              : SYM_W'($urandom);
      send_item(CMD_LOAD, IDX_W'(i), sym);
    end

    // Random segments, each under fresh settings, in three idling phases.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        new_settings();
        seg_len = $urandom_range(20, 60);
        repeat (seg_len) begin
          r = $urandom_range(99);
          if (r < 15) begin
            cmd = CMD_LOAD;
            sym = $urandom_range(1) ? loaded_bytes[$urandom_range(MAX_SYMBOLS - 1)]
                                    : SYM_W'($urandom);
          end else if (r < 19) begin
            cmd = CMD_NONE;
            sym = SYM_W'($urandom);
          end else begin
            cmd = $urandom_range(1) ? CMD_ENCRYPT : CMD_DECRYPT;
            sym = (alphabet_len > 0 && $urandom_range(9) < 7)
                  ? loaded_bytes[$urandom_range(alphabet_len - 1)] : SYM_W'($urandom);
          end
          send_item(cmd, IDX_W'($urandom), sym);
          if (cmd != CMD_NONE) sent++;
        end
      end
    end

    quiesce();
    if (fail_count == 0 && pending_results == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (pending_results != 0) $error("%0d result items never arrived", pending_results);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/asc_pkg.sv
rtl/core/asc_if.sv
rtl/core/asc_ram.sv
rtl/core/asc_modadd.sv
rtl/core/affine_substitution_cipher.sv
test/affine_cipher_checker.sv
test/tb_affine_substitution_cipher.sv
